// ===== hdl/fcaxy_pkg.sv =====
// Shared constants, types and the arctangent table for the full-circle angle block.
package fcaxy_pkg;

   // Number of CORDIC vectoring stages (8 to 32).
   localparam int ITERATIONS = 16;
   // Significant bits of each input coordinate (8 to 16).
   localparam int COORD_WIDTH = 16;

   // Width of one coordinate field on the stream.
   localparam int FIELD_WIDTH = 16;
   // Working width of the coordinate datapath.
   localparam int DATA_WIDTH = 64;
   // Coordinates are placed so that their sign bit lands at this width.
   localparam int SCALED_WIDTH = 60;
   localparam int GUARD_SHIFT = SCALED_WIDTH - COORD_WIDTH;
   // Angle accumulator width, a fraction of one turn.
   localparam int TURN_WIDTH = 32;
   localparam int ANGLE_WIDTH = 16;
   localparam int TABLE_SIZE = 32;

   localparam int REQ_DATA_WIDTH = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = ANGLE_WIDTH;

   typedef logic signed [DATA_WIDTH-1:0] coord_type;
   typedef logic [TURN_WIDTH-1:0] turn_type;
   typedef logic [ANGLE_WIDTH-1:0] angle_type;

   localparam turn_type HALF_TURN = 32'h8000_0000;

   // round(atan(2^-i) / (2*pi) * 2^32)
   localparam turn_type ATAN_TURNS [0:TABLE_SIZE-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

endpackage

// ===== hdl/full_circle_angle_from_xy.sv =====
// Top level: pipelined CORDIC vectoring unit that turns a point (x, y) into its polar angle.
//
// Usage notes.
// The request channel carries one point per item: req_tdata holds x_coord in the
// low half and y_coord in the high half, both two's complement. The response channel
// returns one item per point: rsp_tdata holds the angle as an unsigned fraction of a
// turn (65536 units equal 2*pi, range 0 to just below one turn), and rsp_tuser holds
// the origin flag, which is set when both coordinates are zero; the angle is then 0.
// Throughput is one item per clock while the receiver keeps rsp_tready high: a new
// point can then be accepted in every cycle. The pipeline has ITERATIONS + 2
// register stages: the input stage, one register per CORDIC iteration and the
// output register that does the final rounding.
// When the receiver holds rsp_tready low, items queue up in the pipeline: each stage
// keeps its item only while the stage after it is occupied and stalled, so empty
// slots are squeezed out and req_tready stays high until every stage is full.
// Synchronous reset empties the pipeline; no item is lost or repeated across a stall.
module full_circle_angle_from_xy
   import fcaxy_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,  // [15:0] x_coord, [31:16] y_coord
   // Response channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,  // [15:0] angle
   output logic                      rsp_tuser   // [0] origin_flag
);

   localparam int LAST = ITERATIONS;

   // Pipeline registers: index 0 is the input stage, index k holds the point
   // after k CORDIC iterations.
   coord_type x_ff   [0:LAST];
   coord_type y_ff   [0:LAST];
   turn_type  acc_ff [0:LAST];
   logic      org_ff [0:LAST];
   logic [LAST:0] vld_ff;

   coord_type x_in   [0:LAST];
   coord_type y_in   [0:LAST];
   turn_type  acc_in [0:LAST];
   logic      org_in [0:LAST];
   logic [LAST:0] vld_in;

   // A stage may load when it is empty or its own item moves on.
   logic [LAST+1:0] stg_rdy;

   logic      rsp_valid_ff;
   angle_type angle_ff;
   logic      flag_ff;
   angle_type angle_in;

   // Input stage: sign extension into the working format, origin detection and
   // the half-turn rotation for points in the left half plane.
   logic [DATA_WIDTH-1:0]   x_raw;
   logic [DATA_WIDTH-1:0]   y_raw;
   logic [SCALED_WIDTH-1:0] x_scaled;
   logic [SCALED_WIDTH-1:0] y_scaled;
   coord_type               x_pre;
   coord_type               y_pre;

   always_comb begin
      x_raw    = {{(DATA_WIDTH-FIELD_WIDTH){1'b0}}, req_tdata[FIELD_WIDTH-1:0]};
      y_raw    = {{(DATA_WIDTH-FIELD_WIDTH){1'b0}}, req_tdata[REQ_DATA_WIDTH-1:FIELD_WIDTH]};
      x_scaled = {x_raw[COORD_WIDTH-1:0], {GUARD_SHIFT{1'b0}}};
      y_scaled = {y_raw[COORD_WIDTH-1:0], {GUARD_SHIFT{1'b0}}};
      x_pre    = {{(DATA_WIDTH-SCALED_WIDTH){x_scaled[SCALED_WIDTH-1]}}, x_scaled};
      y_pre    = {{(DATA_WIDTH-SCALED_WIDTH){y_scaled[SCALED_WIDTH-1]}}, y_scaled};
      org_in[0] = (x_raw[COORD_WIDTH-1:0] == '0) && (y_raw[COORD_WIDTH-1:0] == '0);
      vld_in[0] = req_tvalid;
      if (x_pre[DATA_WIDTH-1]) begin
         x_in[0]   = -x_pre;
         y_in[0]   = -y_pre;
         acc_in[0] = HALF_TURN;
      end else begin
         x_in[0]   = x_pre;
         y_in[0]   = y_pre;
         acc_in[0] = '0;
      end
   end

   // One CORDIC vectoring iteration per stage: rotate toward y = 0 and
   // accumulate the matching arctangent.
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      coord_type x_shift;
      coord_type y_shift;

      always_comb begin
         x_shift       = x_ff[i] >>> i;
         y_shift       = y_ff[i] >>> i;
         vld_in[i+1]   = vld_ff[i];
         org_in[i+1]   = org_ff[i];
         if (!y_ff[i][DATA_WIDTH-1]) begin
            x_in[i+1]   = x_ff[i] + y_shift;
            y_in[i+1]   = y_ff[i] - x_shift;
            acc_in[i+1] = acc_ff[i] + ATAN_TURNS[i];
         end else begin
            x_in[i+1]   = x_ff[i] - y_shift;
            y_in[i+1]   = y_ff[i] + x_shift;
            acc_in[i+1] = acc_ff[i] - ATAN_TURNS[i];
         end
      end
   end

   // Ready chain from the output register back to the input.
   always_comb begin
      stg_rdy[LAST+1] = !rsp_valid_ff || rsp_tready;
      for (int k = LAST; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
   end

   // Round the turn fraction to nearest on 16 bits, half up, wrapping at a full turn.
   always_comb begin
      if (org_ff[LAST]) begin
         angle_in = '0;
      end else begin
         angle_in = acc_ff[LAST][TURN_WIDTH-1 -: ANGLE_WIDTH]
                  + {{(ANGLE_WIDTH-1){1'b0}}, acc_ff[LAST][TURN_WIDTH-ANGLE_WIDTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 0; k <= LAST; k++) begin
            if (stg_rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         if (stg_rdy[LAST+1]) begin
            rsp_valid_ff <= vld_ff[LAST];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= LAST; k++) begin
         if (stg_rdy[k]) begin
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            acc_ff[k] <= acc_in[k];
            org_ff[k] <= org_in[k];
         end
      end
      if (stg_rdy[LAST+1]) begin
         angle_ff <= angle_in;
         flag_ff  <= org_ff[LAST];
      end
   end

   assign req_tready = stg_rdy[0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = angle_ff;
   assign rsp_tuser  = flag_ff;

   // An accepted item always lands in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted item missing from the input stage");

   // After the half-turn rotation, x of a real point is never negative.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !org_ff[0] |-> !x_ff[0][DATA_WIDTH-1])
      else $error("input stage x is negative after rotation");

   // The CORDIC gain must not overflow the working width.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !org_ff[LAST] |->
         !x_ff[LAST][DATA_WIDTH-1] && !x_ff[LAST][DATA_WIDTH-2])
      else $error("last stage x out of headroom");

   // An item in the last stage stays there while the output cannot take it.
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAST] && !stg_rdy[LAST+1] |=> vld_ff[LAST])
      else $error("last stage item dropped during a stall");

   // The origin case always reports a zero angle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flag_ff |-> angle_ff == '0)
      else $error("origin item carries a nonzero angle");

endmodule

// ===== dv/tb_full_circle_angle_from_xy.sv =====
// Self-checking testbench for the full-circle angle block: directed and random points.
module tb_full_circle_angle_from_xy
   import fcaxy_pkg::*;
();

   localparam int RANDOM_POINTS = 750;
   // Cycles with no handshake on either channel before the run is declared hung.
   localparam int HANG_LIMIT    = 5000;
   localparam int DRAIN_CYCLES  = ITERATIONS + 2 + 20;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [31:0] TURN_HALF  = 32'h8000_0000;
   localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

   // Arctangent of 2^-i as a fraction of a turn on 32 bits.
   localparam logic [31:0] ARCTAN_STEP [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      angle_type angle;
      logic      origin;
   } polar_type;

   // One directed point; known rows carry an expectation typed in by hand.
   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        known;
      angle_type   angle;
      logic        origin;
   } point_row_type;

   localparam int DIRECTED_ROWS = 21;

   localparam point_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      // Origin: angle 0, flag raised.
      '{16'h0000, 16'h0000, 1'b1, 16'd0,     1'b1},
      // Negative x axis lands on half a turn.
      '{16'hFFFF, 16'h0000, 1'b1, 16'd32768, 1'b0},
      '{16'h8000, 16'h0000, 1'b1, 16'd32768, 1'b0},
      // Positive x axis and the two y axes.
      '{16'h0001, 16'h0000, 1'b0, 16'd0,     1'b0},
      '{16'h7FFF, 16'h0000, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 16'h0001, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 16'h7FFF, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 16'hFFFF, 1'b0, 16'd0,     1'b0},
      '{16'h0000, 16'h8000, 1'b0, 16'd0,     1'b0},
      // Corners of the input range.
      '{16'h7FFF, 16'h7FFF, 1'b0, 16'd0,     1'b0},
      '{16'h8000, 16'h8000, 1'b0, 16'd0,     1'b0},
      '{16'h8000, 16'h7FFF, 1'b0, 16'd0,     1'b0},
      '{16'h7FFF, 16'h8000, 1'b0, 16'd0,     1'b0},
      // Unit diagonals in all four quadrants.
      '{16'h0001, 16'h0001, 1'b0, 16'd0,     1'b0},
      '{16'hFFFF, 16'h0001, 1'b0, 16'd0,     1'b0},
      '{16'hFFFF, 16'hFFFF, 1'b0, 16'd0,     1'b0},
      '{16'h0001, 16'hFFFF, 1'b0, 16'd0,     1'b0},
      // Just below the positive x axis (rounds up to a full turn and wraps), then near the third-quadrant diagonal.
      '{16'h7FFF, 16'hFFFF, 1'b0, 16'd0,     1'b0},
      '{16'h8001, 16'h8000, 1'b0, 16'd0,     1'b0},
      // Alternating bit patterns.
      '{16'h5555, 16'hAAAA, 1'b0, 16'd0,     1'b0},
      '{16'hAAAA, 16'h5555, 1'b0, 16'd0,     1'b0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;  // [15:0] x_coord, [31:16] y_coord
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;      // [15:0] angle
   logic                      rsp_tuser;      // [0] origin_flag

   // Hand-typed expectation that travels with the item on the request channel.
   logic      point_known = 1'b0;
   angle_type point_angle = '0;
   logic      point_origin = 1'b0;

   // While set, neither side inserts idle cycles.
   bit        steady = 1'b0;

   polar_type pending_angles [$];
   int        fault_count = 0;
   int        quiet_cycles = 0;

   full_circle_angle_from_xy uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Full-circle angle of a point by CORDIC vectoring on 64-bit fixed point.
   function automatic polar_type predict_polar(input logic [15:0] x_raw,
                                               input logic [15:0] y_raw);
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic signed [63:0] xs;
      logic signed [63:0] ys;
      logic [31:0]        acc;
      polar_type          result;
      result.angle = '0;
      result.origin = 1'b0;
      // Sign-extend from the significant coordinate width; higher bits drop out.
      px = 64'(x_raw) << (64 - COORD_WIDTH);
      py = 64'(y_raw) << (64 - COORD_WIDTH);
      px = px >>> (64 - COORD_WIDTH);
      py = py >>> (64 - COORD_WIDTH);
      if (px == 0 && py == 0) begin
         result.origin = 1'b1;
         return result;
      end
      px = px <<< GUARD_SHIFT;
      py = py <<< GUARD_SHIFT;
      acc = '0;
      // Left half plane: turn the point by half a turn first.
      if (px < 0) begin
         px = -px;
         py = -py;
         acc = TURN_HALF;
      end
      for (int i = 0; i < ITERATIONS && i < 32; i++) begin
         xs = px >>> i;
         ys = py >>> i;
         if (py >= 0) begin
            px = px + ys;
            py = py - xs;
            acc = acc + ARCTAN_STEP[i];
         end else begin
            px = px - ys;
            py = py + xs;
            acc = acc - ARCTAN_STEP[i];
         end
      end
      acc = acc + ROUND_HALF;
      result.angle = acc[31:16];
      return result;
   endfunction

   // Offers one point, after a random gap unless steady, and holds it until accepted.
   task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic known,
                             input angle_type angle, input logic origin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {y, x};
      point_known <= known;
      point_angle <= angle;
      point_origin <= origin;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Holds the request channel idle until every outstanding angle has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_angles.size() != 0) @(negedge clock);
   endtask

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h8001;
         2: return 16'hFFFF;
         3: return 16'h0000;
         4: return 16'h0001;
         default: return 16'h7FFF;
      endcase
   endfunction

   // Request side: directed table, then random points of several shapes.
   initial begin
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] m;
      int          shape;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_point(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].known,
                    DIRECTED[r].angle, DIRECTED[r].origin);
      end
      wait_for_drain();
      for (int n = 0; n < RANDOM_POINTS; n++) begin
         if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_POINTS / 2) wait_for_drain();
         shape = $urandom_range(0, 99);
         if (shape < 40) begin
            x = 16'($urandom);
            y = 16'($urandom);
         end else if (shape < 60) begin
            x = 16'($urandom_range(0, 32)) - 16'd16;
            y = 16'($urandom_range(0, 32)) - 16'd16;
         end else if (shape < 72) begin
            // On an axis.
            x = 16'($urandom);
            y = 16'h0000;
            if ($urandom_range(0, 1) == 1) begin
               y = x;
               x = 16'h0000;
            end
         end else if (shape < 84) begin
            // On a diagonal, any quadrant.
            m = 16'($urandom_range(1, 32767));
            x = ($urandom_range(0, 1) == 1) ? -m : m;
            y = ($urandom_range(0, 1) == 1) ? -m : m;
         end else if (shape < 97) begin
            x = pick_extreme();
            y = pick_extreme();
         end else begin
            x = 16'h0000;
            y = 16'h0000;
         end
         send_point(x, y, 1'b0, '0, 1'b0);
      end
      req_tvalid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_angles.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Response side: a random stall before each item unless steady.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Records each accepted point's expected angle and checks each returned angle.
   always @(posedge clock) begin
      polar_type want;
      polar_type got;
      int        quiet_next;
      if (!reset) begin
         quiet_next = quiet_cycles + 1;
         if (req_tvalid && req_tready) begin
            quiet_next = 0;
            if (point_known) begin
               want.angle = point_angle;
               want.origin = point_origin;
            end else begin
               want = predict_polar(req_tdata[15:0], req_tdata[31:16]);
            end
            pending_angles.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_next = 0;
            got.angle = rsp_tdata;
            got.origin = rsp_tuser;
            if (pending_angles.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected item: angle %0d origin %0b", got.angle, got.origin);
            end else begin
               want = pending_angles.pop_front();
               if (got.angle !== want.angle || got.origin !== want.origin) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("mismatch: expected angle %0d origin %0b, got angle %0d origin %0b",
                              want.angle, want.origin, got.angle, got.origin);
               end
            end
         end
         quiet_cycles <= quiet_next;
         if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
hdl/fcaxy_pkg.sv
hdl/full_circle_angle_from_xy.sv
dv/tb_full_circle_angle_from_xy.sv
